// ===== rtl/core/vn_pkg.sv =====
// ----------------------------------------------------------------------------
// vn_pkg: shared constants of the 2D vector normalizer
// Fixed-point formats and widths used by the front end, the quotient steps
// and the top level.
// ----------------------------------------------------------------------------
`default_nettype none

package vn_pkg;

  // Width of the component and result fields on the ports.
  localparam int unsigned FieldWidth = 32;
  // Default number of low field bits taken as the two's complement component.
  localparam int unsigned DefaultComponentWidth = 32;
  // Fraction bits of the Q1.30 result.
  localparam int unsigned FracBits = 30;
  // Quotient bits, one pipeline step each.
  localparam int unsigned QuotBits = FracBits + 1;
  // Scale of the squared component in the quotient test (2 * FracBits).
  localparam int unsigned BoundShift = 2 * FracBits;

endpackage

`default_nettype wire

// ===== rtl/core/vn_front.sv =====
// ----------------------------------------------------------------------------
// vn_front: magnitude, squares and sum of squares
// Three register stages that turn the two components into their magnitudes,
// the sum of squares and the starting remainders of the quotient steps.
// ----------------------------------------------------------------------------
`default_nettype none

module vn_front #(
  parameter int unsigned W = vn_pkg::DefaultComponentWidth
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire logic                                  en_i,
  input  wire logic                                  valid_i,
  input  wire logic [vn_pkg::FieldWidth-1:0]         vec_x_i,
  input  wire logic [vn_pkg::FieldWidth-1:0]         vec_y_i,
  output logic                                       valid_o,
  output logic                                       zero_o,
  output logic                                       neg_x_o,
  output logic                                       neg_y_o,
  output logic [2*W-1:0]                             sum_o,
  output logic [2*W+vn_pkg::BoundShift-1:0]          rem_x_o,
  output logic [2*W+vn_pkg::BoundShift-1:0]          rem_y_o
);
  import vn_pkg::*;

  localparam int unsigned SW = 2 * W;
  localparam int unsigned RW = SW + BoundShift;

  logic [W-1:0]  raw_x, raw_y, mag_x_d, mag_y_d;
  logic [W-1:0]  mag_x_q, mag_y_q;
  logic          neg1_x_q, neg1_y_q, v1_q;
  logic [SW-1:0] sq_x_q, sq_y_q;
  logic          neg2_x_q, neg2_y_q, v2_q;
  logic [SW-1:0] sum_q;
  logic [RW-1:0] rem_x_q, rem_y_q;
  logic          neg3_x_q, neg3_y_q, v3_q, zero_q;

  assign raw_x   = vec_x_i[W-1:0];
  assign raw_y   = vec_y_i[W-1:0];
  // The most negative value maps onto 2^(W-1), which still fits in W bits.
  assign mag_x_d = raw_x[W-1] ? (~raw_x + W'(1)) : raw_x;
  assign mag_y_d = raw_y[W-1] ? (~raw_y + W'(1)) : raw_y;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mag_x_q  <= mag_x_d;
      mag_y_q  <= mag_y_d;
      neg1_x_q <= raw_x[W-1];
      neg1_y_q <= raw_y[W-1];
      sq_x_q   <= SW'(mag_x_q) * SW'(mag_x_q);
      sq_y_q   <= SW'(mag_y_q) * SW'(mag_y_q);
      neg2_x_q <= neg1_x_q;
      neg2_y_q <= neg1_y_q;
      sum_q    <= sq_x_q + sq_y_q;
      zero_q   <= (sq_x_q == '0) && (sq_y_q == '0);
      rem_x_q  <= RW'(sq_x_q) << BoundShift;
      rem_y_q  <= RW'(sq_y_q) << BoundShift;
      neg3_x_q <= neg2_x_q;
      neg3_y_q <= neg2_y_q;
    end
  end

  assign valid_o = v3_q;
  assign zero_o  = zero_q;
  assign neg_x_o = neg3_x_q;
  assign neg_y_o = neg3_y_q;
  assign sum_o   = sum_q;
  assign rem_x_o = rem_x_q;
  assign rem_y_o = rem_y_q;

endmodule

`default_nettype wire

// ===== rtl/core/vn_bit_step.sv =====
// ----------------------------------------------------------------------------
// vn_bit_step: one quotient bit of one component
// Tests whether the bit can be set while q^2 * S stays at or below the bound,
// using the running remainder and the running product q * S.
// ----------------------------------------------------------------------------
`default_nettype none

module vn_bit_step #(
  parameter int unsigned W   = vn_pkg::DefaultComponentWidth,
  parameter int unsigned BIT = 0
) (
  input  wire logic                                      clk_i,
  input  wire logic                                      en_i,
  input  wire logic [2*W-1:0]                            sum_i,
  input  wire logic [2*W+vn_pkg::BoundShift-1:0]         rem_i,
  input  wire logic [2*W+vn_pkg::QuotBits-1:0]           qs_i,
  input  wire logic [vn_pkg::QuotBits-1:0]               q_i,
  input  wire logic                                      neg_i,
  output logic [2*W-1:0]                                 sum_o,
  output logic [2*W+vn_pkg::BoundShift-1:0]              rem_o,
  output logic [2*W+vn_pkg::QuotBits-1:0]                qs_o,
  output logic [vn_pkg::QuotBits-1:0]                    q_o,
  output logic                                           neg_o
);
  import vn_pkg::*;

  localparam int unsigned SW  = 2 * W;
  localparam int unsigned RW  = SW + BoundShift;
  localparam int unsigned QSW = SW + QuotBits;
  localparam int unsigned DW  = SW + 2 * QuotBits + 1;

  logic [DW-1:0]  delta;
  logic           take;
  logic [RW-1:0]  rem_d;
  logic [QSW-1:0] qs_d;
  logic [QuotBits-1:0] q_d;

  // Setting the bit raises q^2 * S by 2^(BIT+1) * q * S + 2^(2*BIT) * S.
  always_comb begin
    delta = (DW'(qs_i) << (BIT + 1)) + (DW'(sum_i) << (2 * BIT));
    take  = (delta <= DW'(rem_i));
    rem_d = take ? (rem_i - delta[RW-1:0]) : rem_i;
    qs_d  = take ? (qs_i + (QSW'(sum_i) << BIT)) : qs_i;
    q_d   = q_i | (QuotBits'(take) << BIT);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sum_o <= sum_i;
      rem_o <= rem_d;
      qs_o  <= qs_d;
      q_o   <= q_d;
      neg_o <= neg_i;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/vector_normalize_2d.sv =====
// ----------------------------------------------------------------------------
// vector_normalize_2d: streaming 2D unit-vector pipeline
// Divides each Q16.16 component by the vector magnitude, giving Q1.30.
// ----------------------------------------------------------------------------
// Usage: an input word (vec_x_i, vec_y_i) is taken when vec_valid_i and
// vec_ready_o are both high. Only the low COMPONENT_WIDTH bits of each field
// are used, as two's complement. A result word (unit_x_o, unit_y_o,
// was_zero_o) is offered on unit_valid_o and leaves when unit_ready_i is high.
// Each quotient is the exact value truncated toward zero; a zero vector gives
// zero components with was_zero_o set.
// A word passes three front stages (magnitude, squares, sum), one stage per
// quotient bit for 31 bits, and the output register. One word enters per
// cycle while the output is not stalled; the rate is set by the 31-step
// quotient pipeline, in which every stage holds a different word.
// When the receiver stalls with a result waiting, the whole pipeline holds
// and vec_ready_o drops; no word is lost or repeated. The pipeline advances,
// bubbles included, whenever the output register is empty or being emptied.
// Reset clears every valid bit, so the block comes up empty and ready.
// ----------------------------------------------------------------------------
`default_nettype none

module vector_normalize_2d #(
  parameter int unsigned COMPONENT_WIDTH = vn_pkg::DefaultComponentWidth
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          vec_valid_i,
  output logic                               vec_ready_o,
  input  wire logic [vn_pkg::FieldWidth-1:0] vec_x_i,
  input  wire logic [vn_pkg::FieldWidth-1:0] vec_y_i,
  output logic                               unit_valid_o,
  input  wire logic                          unit_ready_i,
  output logic [vn_pkg::FieldWidth-1:0]      unit_x_o,
  output logic [vn_pkg::FieldWidth-1:0]      unit_y_o,
  output logic                               was_zero_o
);
  import vn_pkg::*;

  localparam int unsigned W   = COMPONENT_WIDTH;
  localparam int unsigned SW  = 2 * W;
  localparam int unsigned RW  = SW + BoundShift;
  localparam int unsigned QSW = SW + QuotBits;

  // Every stage moves together; it stalls only when a finished word waits.
  logic en;
  assign en          = !unit_valid_o || unit_ready_i;
  assign vec_ready_o = en;

  // Index 0 is the front-end output; index k+1 follows quotient step k.
  logic                valid_q [QuotBits+1];
  logic                zero_q  [QuotBits+1];
  logic [SW-1:0]       sum_x   [QuotBits+1];
  logic [SW-1:0]       sum_y   [QuotBits+1];
  logic [RW-1:0]       rem_x   [QuotBits+1];
  logic [RW-1:0]       rem_y   [QuotBits+1];
  logic [QSW-1:0]      qs_x    [QuotBits+1];
  logic [QSW-1:0]      qs_y    [QuotBits+1];
  logic [QuotBits-1:0] q_x     [QuotBits+1];
  logic [QuotBits-1:0] q_y     [QuotBits+1];
  logic                neg_x   [QuotBits+1];
  logic                neg_y   [QuotBits+1];

  vn_front #(.W(W)) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (vec_valid_i),
    .vec_x_i (vec_x_i),
    .vec_y_i (vec_y_i),
    .valid_o (valid_q[0]),
    .zero_o  (zero_q[0]),
    .neg_x_o (neg_x[0]),
    .neg_y_o (neg_y[0]),
    .sum_o   (sum_x[0]),
    .rem_x_o (rem_x[0]),
    .rem_y_o (rem_y[0])
  );

  assign sum_y[0] = sum_x[0];
  assign qs_x[0]  = '0;
  assign qs_y[0]  = '0;
  assign q_x[0]   = '0;
  assign q_y[0]   = '0;

  // One stage per quotient bit, most significant bit first.
  for (genvar k = 0; k < QuotBits; k++) begin : g_step
    vn_bit_step #(.W(W), .BIT(QuotBits - 1 - k)) u_step_x (
      .clk_i (clk_i),
      .en_i  (en),
      .sum_i (sum_x[k]),
      .rem_i (rem_x[k]),
      .qs_i  (qs_x[k]),
      .q_i   (q_x[k]),
      .neg_i (neg_x[k]),
      .sum_o (sum_x[k+1]),
      .rem_o (rem_x[k+1]),
      .qs_o  (qs_x[k+1]),
      .q_o   (q_x[k+1]),
      .neg_o (neg_x[k+1])
    );

    vn_bit_step #(.W(W), .BIT(QuotBits - 1 - k)) u_step_y (
      .clk_i (clk_i),
      .en_i  (en),
      .sum_i (sum_y[k]),
      .rem_i (rem_y[k]),
      .qs_i  (qs_y[k]),
      .q_i   (q_y[k]),
      .neg_i (neg_y[k]),
      .sum_o (sum_y[k+1]),
      .rem_o (rem_y[k+1]),
      .qs_o  (qs_y[k+1]),
      .q_o   (q_y[k+1]),
      .neg_o (neg_y[k+1])
    );

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[k+1] <= 1'b0;
      end else if (en) begin
        valid_q[k+1] <= valid_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        zero_q[k+1] <= zero_q[k];
      end
    end
  end

  // Output register. The quotient never exceeds 2^30, so negation cannot
  // overflow and the Q1.30 range is never reached by a clamp.
  logic                  out_valid_q;
  logic [FieldWidth-1:0] out_x_q, out_y_q, out_x_d, out_y_d;
  logic                  out_zero_q;

  always_comb begin
    out_x_d = FieldWidth'(q_x[QuotBits]);
    out_y_d = FieldWidth'(q_y[QuotBits]);
    if (neg_x[QuotBits]) begin
      out_x_d = ~out_x_d + FieldWidth'(1);
    end
    if (neg_y[QuotBits]) begin
      out_y_d = ~out_y_d + FieldWidth'(1);
    end
    // A zero vector runs through the steps with a zero sum; force the result.
    if (zero_q[QuotBits]) begin
      out_x_d = '0;
      out_y_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= valid_q[QuotBits];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_x_q    <= out_x_d;
      out_y_q    <= out_y_d;
      out_zero_q <= zero_q[QuotBits];
    end
  end

  assign unit_valid_o = out_valid_q;
  assign unit_x_o     = out_x_q;
  assign unit_y_o     = out_y_q;
  assign was_zero_o   = out_zero_q;

`ifndef SYNTHESIS
  // A zero-vector flag always comes with zero components.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    unit_valid_o && was_zero_o |-> unit_x_o == '0 && unit_y_o == '0)
    else $error("zero flag with nonzero components");

  // A nonzero vector gives at least one nonzero component; the larger one
  // has a magnitude of at least about 0.7.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    unit_valid_o && !was_zero_o |-> unit_x_o != '0 || unit_y_o != '0)
    else $error("nonzero vector gave a zero result");

  // Unit components stay within plus and minus one in Q1.30.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    unit_valid_o |-> $signed(unit_x_o) <= $signed(32'sh4000_0000) &&
                     $signed(unit_x_o) >= $signed(32'shC000_0000) &&
                     $signed(unit_y_o) <= $signed(32'sh4000_0000) &&
                     $signed(unit_y_o) >= $signed(32'shC000_0000))
    else $error("unit component out of range");

  // The input side stalls only while a finished word is refused.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !vec_ready_o |-> unit_valid_o && !unit_ready_i)
    else $error("input stalled without an output stall");

  // A held result does not change while refused.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    unit_valid_o && !unit_ready_i |=> unit_valid_o && $stable(unit_x_o) &&
                                      $stable(unit_y_o) && $stable(was_zero_o))
    else $error("refused result changed");
`endif

endmodule

`default_nettype wire
